@@ hdl/fsk_pkg.sv @@
// fsk_pkg: shared constants, types and the quarter-wave sine table of the FSK demodulator.
// No dependencies; every other file of the block but fsk_checker imports it.
`default_nettype none
package fsk_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int FILTER_STAGES   = 4;

  localparam int QB       = SINE_TABLE_BITS - 2;
  localparam int QUARTER  = 1 << QB;
  localparam int STG_W    = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;
  localparam int TAP_W    = $clog2(4 * FILTER_STAGES);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int TIMER_W  = 25;
  localparam logic [STG_W-1:0] LAST_STG = STG_W'(FILTER_STAGES - 1);
  localparam logic [TIMER_W-1:0] ONE_SAMPLE = TIMER_W'(256);

  localparam longint unsigned SIN_A1 = 64'd1686629713;
  localparam longint unsigned SIN_A3 = 64'd693598564;
  localparam longint unsigned SIN_A5 = 64'd85569278;
  localparam longint unsigned SIN_A7 = 64'd5027044;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_STEP  = 2'd0,
    REG_HIGH_STEP = 2'd1,
    REG_ALPHA     = 2'd2,
    REG_PERIOD    = 2'd3
  } cfg_reg_e;

  localparam logic [1:0] TONE_LOW  = 2'd0;
  localparam logic [1:0] TONE_HIGH = 2'd1;
  localparam logic [1:0] TONE_NONE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_MIX, ST_FMUL, ST_FUPD, ST_SQ, ST_ACC, ST_DECIDE
  } state_e;

  typedef enum logic [1:0] {
    MUL_MIX, MUL_FILT, MUL_SQ
  } mul_op_e;

  typedef struct packed {
    logic             load;
    logic             rom_rd;
    logic             mul_en;
    mul_op_e          mul_op;
    logic             tap_wr;
    logic             acc_en;
    logic             decide;
    logic [1:0]       ch;
    logic [STG_W-1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  typedef logic [QUARTER:0][14:0] sine_rom_t;

  // Quarter-wave magnitude, odd polynomial in Q30, rounded to Q15.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned u, u2, p, y;
    for (int r = 0; r <= QUARTER; r++) begin
      u  = longint'(r) << (30 - QB);
      u2 = (u * u) >> 30;
      p  = SIN_A7;
      p  = SIN_A5 - ((p * u2) >> 30);
      p  = SIN_A3 - ((p * u2) >> 30);
      p  = SIN_A1 - ((p * u2) >> 30);
      y  = (p * u) >> 30;
      y  = (y + 64'd16384) >> 15;
      if (y > 64'd32767) y = 64'd32767;
      rom[r] = y[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

@@ hdl/fsk_if.sv @@
// Stream interfaces of the FSK demodulator: sample input and bit output.
// Depends on fsk_pkg for the sample width.
`default_nettype none
interface fsk_sample_if;
  import fsk_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fsk_bit_if;
  logic valid;
  logic ready;
  logic bit_out;
  modport source (output valid, output bit_out, input ready);
  modport sink (input valid, input bit_out, output ready);
endinterface
`default_nettype wire

@@ hdl/fsk_ctrl.sv @@
// fsk_ctrl: sequencer that steps the shared multiplier through mix, filter and power.
// Depends on fsk_pkg for state, command and status types.
`default_nettype none
module fsk_ctrl
  import fsk_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e           state_q, state_d;
  logic [1:0]       ch_q, ch_d;
  logic [STG_W-1:0] stg_q, stg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      stg_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      stg_q   <= stg_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    stg_d      = stg_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ch   = ch_q;
    cmd_o.stage = stg_q;
    cmd_o.mul_op = MUL_MIX;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ch_d       = '0;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_MIX;
        stg_d        = '0;
        state_d      = ST_FMUL;
      end
      ST_FMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_FILT;
        state_d      = ST_FUPD;
      end
      ST_FUPD: begin
        cmd_o.tap_wr = 1'b1;
        if (stg_q == LAST_STG) begin
          ch_d = ch_q + 2'd1;
          state_d = (ch_q == 2'd3) ? ST_SQ : ST_LOOK;
        end else begin
          stg_d   = stg_q + STG_W'(1);
          state_d = ST_FMUL;
        end
      end
      ST_SQ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_SQ;
        cmd_o.stage  = LAST_STG;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        ch_d         = ch_q + 2'd1;
        state_d      = (ch_q == 2'd3) ? ST_DECIDE : ST_SQ;
      end
      ST_DECIDE: begin
        if (!status_i.out_busy) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/fsk_datapath.sv @@
// fsk_datapath: config registers, NCOs, sine ROM, shared multiplier, filter taps, bit timer.
// Depends on fsk_pkg; driven by fsk_ctrl commands.
`default_nettype none
module fsk_datapath
  import fsk_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cmd_t                          cmd_i,
  output status_t                            status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               bit_out_o
);

  logic [30:0] lstep_q, hstep_q;
  logic [15:0] alpha_q;
  logic [23:0] period_q;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [31:0] lphase_q, hphase_q;
  logic [14:0] mag_q;
  logic        neg_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] in_q;
  logic signed [31:0] taps_q [4*FILTER_STAGES];
  logic [63:0] lpow_q, hpow_q;
  logic [1:0]  last_q;
  logic [TIMER_W-1:0] timer_q;
  logic out_valid_q, bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lstep_q  <= '0;
      hstep_q  <= '0;
      alpha_q  <= '0;
      period_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_STEP:  lstep_q  <= cfg_data_i;
        REG_HIGH_STEP: hstep_q  <= cfg_data_i;
        REG_ALPHA:     alpha_q  <= cfg_data_i[15:0];
        REG_PERIOD:    period_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Sine ROM address
  logic [31:0]                phase;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [1:0]                 quad;
  logic [QB:0]                r;
  assign phase = cmd_i.ch[1] ? hphase_q : lphase_q;
  assign k     = phase[31 -: SINE_TABLE_BITS]
               + (cmd_i.ch[0] ? SINE_TABLE_BITS'(0) : SINE_TABLE_BITS'(QUARTER));
  assign quad  = k[SINE_TABLE_BITS-1 -: 2];
  always_comb begin
    r = {1'b0, k[QB-1:0]};
    if (quad[0]) r = (QB+1)'(QUARTER) - r;
  end

  // Tap select
  logic [TAP_W-1:0]   tap_idx;
  logic signed [31:0] tap_rd;
  assign tap_idx = TAP_W'(cmd_i.ch) * TAP_W'(FILTER_STAGES) + TAP_W'(cmd_i.stage);
  assign tap_rd  = taps_q[tap_idx];

  // Shared multiplier operands
  logic signed [23:0] s24;
  logic signed [15:0] w;
  logic signed [31:0] fin;
  logic signed [32:0] op_a, op_b;
  assign s24 = 24'(sample_q) <<< (24 - SAMPLE_BITS);
  assign w   = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign fin = (cmd_i.stage == '0) ? prod_q[39:8] : in_q;
  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_MIX: begin
        op_a = 33'(s24);
        op_b = 33'(w);
      end
      MUL_FILT: begin
        op_a = 33'(fin) - 33'(tap_rd);
        op_b = $signed({17'b0, alpha_q});
      end
      MUL_SQ: begin
        op_a = 33'(tap_rd);
        op_b = 33'(tap_rd);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  logic signed [32:0] y_new;
  assign y_new = 33'(tap_rd) + prod_q[48:16];

  // Decision and bit timer
  logic               tone;
  logic               changed;
  logic [TIMER_W-1:0] t;
  logic               emit;
  assign tone    = hpow_q > lpow_q;
  assign changed = last_q != {1'b0, tone};
  assign t       = changed ? TIMER_W'(period_q >> 1) : timer_q;
  assign emit    = t <= ONE_SAMPLE;
  assign status_o.out_busy = emit && out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) sample_q <= sample_i;
    if (cmd_i.rom_rd) begin
      mag_q <= SINE_ROM[r];
      neg_q <= quad[1];
    end
    if (cmd_i.mul_en) prod_q <= 66'(op_a * op_b);
    if (cmd_i.tap_wr) in_q <= y_new[31:0];
    if (cmd_i.decide && emit) bit_q <= tone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lphase_q <= '0;
      hphase_q <= '0;
      for (int i = 0; i < 4*FILTER_STAGES; i++) taps_q[i] <= '0;
      lpow_q <= '0;
      hpow_q <= '0;
      last_q <= TONE_NONE;
      timer_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        lphase_q <= lphase_q + {1'b0, lstep_q};
        hphase_q <= hphase_q + {1'b0, hstep_q};
        lpow_q   <= '0;
        hpow_q   <= '0;
      end
      if (cmd_i.tap_wr) taps_q[tap_idx] <= y_new[31:0];
      if (cmd_i.acc_en) begin
        if (cmd_i.ch[1]) hpow_q <= hpow_q + prod_q[63:0];
        else             lpow_q <= lpow_q + prod_q[63:0];
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.decide) begin
        last_q <= {1'b0, tone};
        if (emit) begin
          timer_q     <= TIMER_W'(period_q);
          out_valid_q <= 1'b1;
        end else begin
          timer_q <= t - ONE_SAMPLE;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign bit_out_o   = bit_q;

endmodule
`default_nettype wire

@@ hdl/fsk_tone_demodulator.sv @@
// Noncoherent FSK tone demodulator: one signed audio sample in, at most one bit out.
// Samples are taken one at a time, paced by the single shared multiplier
//   that runs mix, every filter stage and the four squares in turn.
// Reset: rst_ni async low; phases, taps, timer and config clear, last tone reads "none seen".
// Depends on fsk_pkg, fsk_if, fsk_ctrl and fsk_datapath.
`default_nettype none
module fsk_tone_demodulator
  import fsk_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  fsk_sample_if.sink                 in_if,
  fsk_bit_if.source                  out_if
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: takes a sample beat only when idle, then walks the datapath.
  fsk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: output register holds the bit beat, so the next sample is taken while it waits.
  fsk_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (in_if.sample),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .bit_out_o   (out_if.bit_out)
  );

endmodule
`default_nettype wire

@@ hdl/fsk_checker.sv @@
// fsk_checker: port-level assertions on the demodulator, bound to the top level.
// Depends only on the top-level port signals.
`default_nettype none
module fsk_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_bit_i
);

  // Hold a stalled output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bit_i))
    else $error("output beat dropped or changed while stalled");

  // One sample at a time: no input beat right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a sample is in work");

  // A bit beat cannot appear in the cycle right after a sample beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("bit beat too early after sample");

endmodule

bind fsk_tone_demodulator fsk_checker u_fsk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_bit_i   (out_if.bit_out)
);
`default_nettype wire
